// ===== rtl/frag_pkg.sv =====
package frag_pkg;

  localparam int MAX_MESSAGE = 512;
  localparam int STORE_AW    = 9;

  localparam logic [7:0] FLAG_FIRST_BIT = 8'h01;
  localparam logic [7:0] FLAG_LAST_BIT  = 8'h02;

  localparam logic [9:0]  COUNT_MAX      = 10'd1023;
  localparam logic [9:0]  CAPACITY_RESET = 10'd512;
  localparam logic [10:0] HDR_BYTES      = 11'd2;
  localparam logic [10:0] FIRST_HDR      = 11'd4;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       frame_end;
    logic [8:0] read_index;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== rtl/fragment_reassembler_unit.sv =====
// An input transfer passes through the front register, a queue entry and the result
// register before its result is offered. Throughput: one item per cycle while out_stall
// is low; the back unit does one store write or read per cycle.
// Stalls on the output are absorbed by a two-entry queue between front and back.
// Reset (rst, synchronous, active high) clears assembler state, the frame counter,
// the queue and valid flags, and sets capacity to 512; the message store is not cleared.
module fragment_reassembler_unit (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] data,
  input  logic       frame_end,
  input  logic [8:0] read_index,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       frame_done,
  output logic       accepted,
  output logic       complete,
  output logic [9:0] message_length,
  output logic [7:0] read_data
);

  logic                  queue_full;
  logic                  push;
  logic                  pop;
  frag_pkg::item_t       push_item;
  frag_pkg::queue_head_t head;

  // front: registers and decodes each transfer
  frag_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .data       (data),
    .frame_end  (frame_end),
    .read_index (read_index),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // short queue decoupling the two sides
  frag_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  // back: frame checks, message store and result register
  frag_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_done     (frame_done),
    .accepted       (accepted),
    .complete       (complete),
    .message_length (message_length),
    .read_data      (read_data)
  );

  // a verdict only comes with a closed frame
  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> frame_done)
    else $error("accepted without frame_done");

  // read data and frame close never share a result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> read_data == 8'd0)
    else $error("read data on frame result");

  // front only pushes into a queue with room
  assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("queue overflow");

endmodule

// ===== rtl/frag_front.sv =====
module frag_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  logic [7:0]       data,
  input  logic             frame_end,
  input  logic [8:0]       read_index,
  input  logic             queue_full,
  output logic             push,
  output frag_pkg::item_t  push_item
);

  logic            held;
  frag_pkg::item_t item;

  assign in_stall  = held && queue_full;
  assign push      = held && !queue_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  // decode op into the queue entry form
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.op         <= frag_pkg::op_t'(op);
      item.data       <= data;
      item.frame_end  <= frame_end;
      item.read_index <= read_index;
    end
  end

endmodule

// ===== rtl/frag_queue.sv =====
module frag_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  frag_pkg::item_t        push_item,
  output logic                   full,
  input  logic                   pop,
  output frag_pkg::queue_head_t  head
);

  frag_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_pop;

  assign full       = (count == 2'd2);
  assign do_pop     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/frag_back.sv =====
module frag_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [9:0]             cfg_data,
  input  frag_pkg::queue_head_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   frame_done,
  output logic                   accepted,
  output logic                   complete,
  output logic [9:0]             message_length,
  output logic [7:0]             read_data
);

  logic [7:0]  store [frag_pkg::MAX_MESSAGE];

  logic [9:0]  capacity;
  logic [9:0]  total_length, total_length_next;
  logic [9:0]  filled_count, filled_count_next;
  logic [7:0]  expected_sequence, expected_sequence_next;
  logic        assembling, assembling_next;
  logic        message_complete, message_complete_next;
  logic [9:0]  frame_byte_count, frame_byte_count_next;
  logic [7:0]  frame_sequence, frame_sequence_next;
  logic [7:0]  frame_flags, frame_flags_next;
  logic [15:0] announced_length, announced_length_next;

  logic        read_sel;
  logic [7:0]  read_raw;

  frag_pkg::item_t it;
  logic        is_frame, first, last, stream_ok, hdr_byte, fail, we, done;
  logic [9:0]  cnt_inc;
  logic [10:0] len, hdr, n, sum, pos, base, tot;
  logic [15:0] limit;

  assign pop       = !out_valid || !out_stall;
  assign it        = head.item;
  assign is_frame  = (it.op == frag_pkg::OP_FRAME);
  assign read_data = read_sel ? read_raw : 8'd0;

  function automatic logic length_ok(input logic [15:0] l, input logic [9:0] cap);
    length_ok = (l <= 16'(frag_pkg::MAX_MESSAGE)) && (l <= {6'd0, cap});
  endfunction

  always_comb begin
    frame_sequence_next   = (frame_byte_count == 10'd0) ? it.data : frame_sequence;
    frame_flags_next      = (frame_byte_count == 10'd1) ? it.data : frame_flags;
    first                 = (frame_flags_next & frag_pkg::FLAG_FIRST_BIT) != 8'd0;
    last                  = (frame_flags_next & frag_pkg::FLAG_LAST_BIT) != 8'd0;
    hdr                   = first ? frag_pkg::FIRST_HDR : frag_pkg::HDR_BYTES;
    hdr_byte              = first && (frame_byte_count == 10'd2 || frame_byte_count == 10'd3);
    announced_length_next = announced_length;
    if (frame_byte_count == 10'd0) begin
      announced_length_next = 16'd0;
    end else if (first && frame_byte_count == 10'd2) begin
      announced_length_next = {it.data, announced_length[7:0]};
    end else if (first && frame_byte_count == 10'd3) begin
      announced_length_next = {announced_length[15:8], it.data};
    end

    // streaming store write
    if (first) begin
      stream_ok = !assembling && frame_sequence == 8'd0 && length_ok(announced_length, capacity);
      base      = 11'd0;
      limit     = announced_length;
    end else begin
      stream_ok = assembling && frame_sequence == expected_sequence;
      base      = {1'b0, filled_count};
      limit     = {6'd0, total_length};
    end
    pos = base + ({1'b0, frame_byte_count} - hdr);
    we  = head.valid && pop && is_frame && !message_complete && !hdr_byte
          && frame_byte_count >= 10'd2 && ({1'b0, frame_byte_count} >= hdr)
          && stream_ok && ({5'd0, pos} < limit) && (pos < 11'(frag_pkg::MAX_MESSAGE));

    cnt_inc = (frame_byte_count < frag_pkg::COUNT_MAX) ? frame_byte_count + 10'd1
                                                        : frame_byte_count;
    len = {1'b0, cnt_inc};

    // frame close checks
    fail = message_complete || len < frag_pkg::HDR_BYTES;
    if (first) begin
      fail = fail || assembling || frame_sequence_next != 8'd0 || len < frag_pkg::FIRST_HDR
             || !length_ok(announced_length_next, capacity);
      tot  = {1'b0, announced_length_next[9:0]};
      base = 11'd0;
    end else begin
      fail = fail || !assembling || frame_sequence_next != expected_sequence;
      tot  = {1'b0, total_length};
      base = {1'b0, filled_count};
    end
    n    = len - hdr;
    sum  = base + n;
    fail = fail || (sum > tot) || (last && sum != tot);

    done                   = is_frame && it.frame_end;
    total_length_next      = total_length;
    filled_count_next      = filled_count;
    expected_sequence_next = expected_sequence;
    assembling_next        = assembling;
    message_complete_next  = message_complete;
    frame_byte_count_next  = frame_byte_count;
    if (!is_frame) begin
      frame_sequence_next   = frame_sequence;
      frame_flags_next      = frame_flags;
      announced_length_next = announced_length;
    end

    case (it.op)
      frag_pkg::OP_FRAME: begin
        frame_byte_count_next = it.frame_end ? 10'd0 : cnt_inc;
        if (it.frame_end) begin
          if (fail) begin
            total_length_next      = 10'd0;
            filled_count_next      = 10'd0;
            expected_sequence_next = 8'd0;
            assembling_next        = 1'b0;
            message_complete_next  = 1'b0;
          end else begin
            total_length_next      = tot[9:0];
            filled_count_next      = sum[9:0];
            expected_sequence_next = frame_sequence_next + 8'd1;
            assembling_next        = 1'b1;
            message_complete_next  = last;
          end
        end
      end
      frag_pkg::OP_CLEAR: begin
        total_length_next      = 10'd0;
        filled_count_next      = 10'd0;
        expected_sequence_next = 8'd0;
        assembling_next        = 1'b0;
        message_complete_next  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity          <= frag_pkg::CAPACITY_RESET;
      total_length      <= 10'd0;
      filled_count      <= 10'd0;
      expected_sequence <= 8'd0;
      assembling        <= 1'b0;
      message_complete  <= 1'b0;
      frame_byte_count  <= 10'd0;
      frame_sequence    <= 8'd0;
      frame_flags       <= 8'd0;
      announced_length  <= 16'd0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (pop) out_valid <= head.valid;
      if (pop && head.valid) begin
        total_length      <= total_length_next;
        filled_count      <= filled_count_next;
        expected_sequence <= expected_sequence_next;
        assembling        <= assembling_next;
        message_complete  <= message_complete_next;
        frame_byte_count  <= frame_byte_count_next;
        frame_sequence    <= frame_sequence_next;
        frame_flags       <= frame_flags_next;
        announced_length  <= announced_length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) store[pos[frag_pkg::STORE_AW-1:0]] <= it.data;
  end

  always_ff @(posedge clk) begin
    if (pop && head.valid) begin
      frame_done     <= done;
      accepted       <= done && !fail;
      complete       <= message_complete_next;
      message_length <= total_length_next;
      read_sel       <= (it.op == frag_pkg::OP_READ);
      read_raw       <= store[it.read_index];
    end
  end

endmodule
